// ----- hw/rtl/pgbf_pkg.sv -----
// ----------------------------------------------------------------------------
// pgbf_pkg
// Shared constants and types for the peer group boundary finder: bitmap
// geometry, field widths, register and item codes, bit scan request types.
// ----------------------------------------------------------------------------
`default_nettype none

package pgbf_pkg;

    // bitmap geometry
    localparam int MAX_ROWS     = 4096;
    localparam int WORD_BITS    = 64;
    localparam int BITMAP_DEPTH = MAX_ROWS / WORD_BITS;

    // widths
    localparam int ROW_W   = 12;               // row number
    localparam int CNT_W   = 13;               // row count, can hold MAX_ROWS
    localparam int BIT_W   = 6;                // bit position inside a word
    localparam int ADDR_W  = 6;                // word address
    localparam int WCNT_W  = 7;                // word count register
    localparam int MODE_W  = 2;                // boundary mode register
    localparam int CIDX_W  = 2;                // configuration index
    localparam int GRP_W   = 8;                // bits per scan group
    localparam int NGRP    = WORD_BITS / GRP_W;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BOUNDARY_MODE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NUM_ROWS      = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BITMAP_WORDS  = 2'd2;

    // boundary modes
    localparam logic [MODE_W-1:0] BMODE_PARTITION = 2'd0;
    localparam logic [MODE_W-1:0] BMODE_SINGLE    = 2'd1;

    // request kinds
    localparam logic ITEM_LOAD  = 1'b0;
    localparam logic ITEM_QUERY = 1'b1;

    // bit scan request: keep bits lo..hi, find lowest or highest set bit
    typedef struct packed {
        logic [BIT_W-1:0] lo;
        logic [BIT_W-1:0] hi;
        logic             from_top;
    } scan_req_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } scan_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pgbf_bit_scan.sv -----
// ----------------------------------------------------------------------------
// pgbf_bit_scan
// Shared search unit: masks one bitmap word to a bit window and returns the
// lowest or highest set bit in it, as a two-level search over groups of eight.
// ----------------------------------------------------------------------------
`default_nettype none

module pgbf_bit_scan
    import pgbf_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] word,
    input  wire scan_req_t            req,
    output scan_rsp_t                 rsp
);

    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] oriented;
    logic [NGRP-1:0]      grp_any;
    logic [BIT_W-4:0]     grp_sel;
    logic [GRP_W-1:0]     grp_bits;
    logic [2:0]           bit_sel;
    logic [BIT_W-1:0]     low_pos;

    // keep only the bits inside the window
    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            masked[k] = word[k] && (BIT_W'(k) >= req.lo) && (BIT_W'(k) <= req.hi);
        end
    end

    // reverse for a search from the top so one lowest-bit finder serves both
    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            oriented[k] = req.from_top ? masked[WORD_BITS-1-k] : masked[k];
        end
    end

    // group level: lowest group holding a set bit
    always_comb
    begin
        grp_sel = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any[g] = |oriented[g*GRP_W +: GRP_W];
        end
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                grp_sel = 3'(g);
            end
        end
    end

    // bit level inside the chosen group
    always_comb
    begin
        bit_sel  = '0;
        grp_bits = oriented[grp_sel*GRP_W +: GRP_W];
        for (int b = GRP_W - 1; b >= 0; b--)
        begin
            if (grp_bits[b])
            begin
                bit_sel = 3'(b);
            end
        end
    end

    assign low_pos   = {grp_sel, bit_sel};
    assign rsp.found = |grp_any;
    assign rsp.pos   = req.from_top ? ~low_pos : low_pos;

endmodule

`default_nettype wire

// ----- hw/rtl/peer_group_boundary_finder_core.sv -----
// ----------------------------------------------------------------------------
// peer_group_boundary_finder_core
// Holds the peer start bitmap and answers row queries with the first and last
// row of the row's peer group; the last group found is cached.
// ----------------------------------------------------------------------------
// load request: taken while idle, the next request may follow at once
// query request: the evaluate state sends a group from the mode or the cache
//   straight to the done state; a cache miss scans bitmap words backward for
//   the group start, then a setup state precedes a forward scan for its end
// one bitmap word is searched per cycle through the single bit scan unit
// reset: asynchronous; clears config/state registers, cache, per-word valid bits
`default_nettype none

module peer_group_boundary_finder_core
    import pgbf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CIDX_W-1:0]    cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data,
    // request channel
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic                 mode,
    input  wire logic [ADDR_W-1:0]    word_index,
    input  wire logic [WORD_BITS-1:0] word_data,
    input  wire logic [ROW_W-1:0]     row_index,
    input  wire logic                 last_row,
    // result channel
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [ROW_W-1:0]          group_first,
    output logic [ROW_W-1:0]          group_last,
    output logic                      error,
    output logic                      last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_B_CHK = 3'd2;
    localparam logic [2:0] ST_F_SET = 3'd3;
    localparam logic [2:0] ST_F_CHK = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [MODE_W-1:0]    bmode_reg;
    logic [CNT_W-1:0]     num_rows_reg;
    logic [WCNT_W-1:0]    bitmap_words_reg;
    logic [CNT_W-1:0]     cache_first_reg, cache_first_next;
    logic [CNT_W-1:0]     cache_end_reg, cache_end_next;
    logic [ROW_W-1:0]     row_reg;
    logic                 last_reg;
    logic [CNT_W-1:0]     first_reg, first_next;
    logic [CNT_W-1:0]     end_reg, end_next;
    logic                 err_reg, err_next;
    logic [ADDR_W-1:0]    scan_word_reg, scan_word_next;
    logic [ADDR_W-1:0]    scan_end_word_reg, scan_end_word_next;
    logic [BIT_W-1:0]     scan_lo_reg, scan_lo_next;
    logic [BIT_W-1:0]     scan_hi_reg, scan_hi_next;
    logic                 first_word_reg, first_word_next;
    logic                 result_valid_reg, result_valid_next;
    logic [ROW_W-1:0]     group_first_reg;
    logic [ROW_W-1:0]     group_last_reg;
    logic                 error_reg;
    logic                 last_out_reg;

    logic [WORD_BITS-1:0] bitmap_mem [BITMAP_DEPTH];
    logic [BITMAP_DEPTH-1:0] word_valid_reg;
    logic [WORD_BITS-1:0] mem_rdata_reg;
    logic                 mem_rvld_reg;
    logic [WORD_BITS-1:0] scan_word_data;

    logic                 item_accept;
    logic                 out_load;
    logic [CNT_W-1:0]     n_eff;
    logic [WCNT_W-1:0]    words_eff;
    logic [CNT_W-1:0]     bits_eff;
    logic [CNT_W-1:0]     row_ext;
    logic [CNT_W-1:0]     row_plus1;
    logic [CNT_W-1:0]     lim_back;
    logic [CNT_W-1:0]     top_bit;
    logic [CNT_W-1:0]     start_plus1;
    logic [CNT_W-1:0]     lim_fwd;
    logic [CNT_W-1:0]     last_bit;
    logic [CNT_W-1:0]     end_minus1;
    scan_req_t            scan_req;
    scan_rsp_t            scan_rsp;

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    // effective limits of the partition and the bitmap
    assign n_eff     = (num_rows_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : num_rows_reg;
    assign words_eff = (bitmap_words_reg > WCNT_W'(BITMAP_DEPTH))
                     ? WCNT_W'(BITMAP_DEPTH) : bitmap_words_reg;
    assign bits_eff  = {words_eff, {BIT_W{1'b0}}};

    // backward search window
    assign row_ext   = {1'b0, row_reg};
    assign row_plus1 = row_ext + CNT_W'(1);
    assign lim_back  = (row_plus1 > bits_eff) ? bits_eff : row_plus1;
    assign top_bit   = lim_back - CNT_W'(1);

    // forward search window
    assign start_plus1 = first_reg + CNT_W'(1);
    assign lim_fwd     = (n_eff < bits_eff) ? n_eff : bits_eff;
    assign last_bit    = lim_fwd - CNT_W'(1);
    assign end_minus1  = end_reg - CNT_W'(1);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bmode_reg        <= '0;
            num_rows_reg     <= '0;
            bitmap_words_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BOUNDARY_MODE: bmode_reg        <= cfg_data[MODE_W-1:0];
                CFG_NUM_ROWS:      num_rows_reg     <= cfg_data;
                CFG_BITMAP_WORDS:  bitmap_words_reg <= cfg_data[WCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // bitmap memory, read address is the next scan word so data lines up with the scan word register
    always_ff @(posedge clk)
    begin
        if (item_accept && (mode == ITEM_LOAD))
        begin
            bitmap_mem[word_index] <= word_data;
        end
        mem_rdata_reg <= bitmap_mem[scan_word_next];
        mem_rvld_reg  <= word_valid_reg[scan_word_next];
    end

    // per-word valid bits, a word never loaded reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
        end
        else if (item_accept && (mode == ITEM_LOAD))
        begin
            word_valid_reg[word_index] <= 1'b1;
        end
    end

    assign scan_word_data = mem_rvld_reg ? mem_rdata_reg : '0;

    // window for the shared bit scan unit
    always_comb
    begin
        if (state_reg == ST_B_CHK)
        begin
            scan_req.lo       = (scan_word_reg == '0) ? BIT_W'(1) : '0;
            scan_req.hi       = first_word_reg ? scan_hi_reg : '1;
            scan_req.from_top = 1'b1;
        end
        else
        begin
            scan_req.lo       = first_word_reg ? scan_lo_reg : '0;
            scan_req.hi       = (scan_word_reg == scan_end_word_reg) ? scan_hi_reg : '1;
            scan_req.from_top = 1'b0;
        end
    end

    pgbf_bit_scan u_scan (
        .word (scan_word_data),
        .req  (scan_req),
        .rsp  (scan_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        first_next         = first_reg;
        end_next           = end_reg;
        err_next           = err_reg;
        scan_word_next     = scan_word_reg;
        scan_end_word_next = scan_end_word_reg;
        scan_lo_next       = scan_lo_reg;
        scan_hi_next       = scan_hi_reg;
        first_word_next    = first_word_reg;
        cache_first_next   = cache_first_reg;
        cache_end_next     = cache_end_reg;
        out_load           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && (mode == ITEM_QUERY))
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                err_next = 1'b0;
                if (row_ext >= n_eff)
                begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (bmode_reg == BMODE_PARTITION)
                begin
                    first_next = '0;
                    end_next   = n_eff;
                    state_next = ST_DONE;
                end
                else if (bmode_reg == BMODE_SINGLE)
                begin
                    first_next = row_ext;
                    end_next   = row_plus1;
                    state_next = ST_DONE;
                end
                else if ((row_reg != '0) && (row_ext >= cache_first_reg)
                         && (row_ext < cache_end_reg))
                begin
                    first_next = cache_first_reg;
                    end_next   = cache_end_reg;
                    state_next = ST_DONE;
                end
                else if ((row_reg == '0) || (bitmap_words_reg == '0)
                         || (lim_back <= CNT_W'(1)))
                begin
                    first_next = '0;
                    state_next = ST_F_SET;
                end
                else
                begin
                    scan_word_next  = top_bit[ROW_W-1:BIT_W];
                    scan_hi_next    = top_bit[BIT_W-1:0];
                    first_word_next = 1'b1;
                    state_next      = ST_B_CHK;
                end
            end

            // walk words downward for the group start
            ST_B_CHK:
            begin
                if (scan_rsp.found)
                begin
                    first_next = {1'b0, scan_word_reg, scan_rsp.pos};
                    state_next = ST_F_SET;
                end
                else if (scan_word_reg == '0)
                begin
                    first_next = '0;
                    state_next = ST_F_SET;
                end
                else
                begin
                    scan_word_next  = scan_word_reg - ADDR_W'(1);
                    first_word_next = 1'b0;
                end
            end

            ST_F_SET:
            begin
                if (start_plus1 >= lim_fwd)
                begin
                    end_next   = n_eff;
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_word_next     = start_plus1[ROW_W-1:BIT_W];
                    scan_lo_next       = start_plus1[BIT_W-1:0];
                    scan_end_word_next = last_bit[ROW_W-1:BIT_W];
                    scan_hi_next       = last_bit[BIT_W-1:0];
                    first_word_next    = 1'b1;
                    state_next         = ST_F_CHK;
                end
            end

            // walk words upward for the next group start
            ST_F_CHK:
            begin
                if (scan_rsp.found)
                begin
                    end_next   = {1'b0, scan_word_reg, scan_rsp.pos};
                    state_next = ST_DONE;
                end
                else if (scan_word_reg == scan_end_word_reg)
                begin
                    end_next   = n_eff;
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_word_next  = scan_word_reg + ADDR_W'(1);
                    first_word_next = 1'b0;
                end
            end

            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (!err_reg)
                    begin
                        cache_first_next = first_reg;
                        cache_end_next   = end_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cache_first_reg  <= '0;
            cache_end_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cache_first_reg  <= cache_first_next;
            cache_end_reg    <= cache_end_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // request and working registers
    always_ff @(posedge clk)
    begin
        if (item_accept && (mode == ITEM_QUERY))
        begin
            row_reg  <= row_index;
            last_reg <= last_row;
        end
        first_reg         <= first_next;
        end_reg           <= end_next;
        err_reg           <= err_next;
        scan_word_reg     <= scan_word_next;
        scan_end_word_reg <= scan_end_word_next;
        scan_lo_reg       <= scan_lo_next;
        scan_hi_reg       <= scan_hi_next;
        first_word_reg    <= first_word_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            group_first_reg <= err_reg ? '0 : first_reg[ROW_W-1:0];
            group_last_reg  <= err_reg ? '0 : end_minus1[ROW_W-1:0];
            error_reg       <= err_reg;
            last_out_reg    <= last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign group_first  = group_first_reg;
    assign group_last   = group_last_reg;
    assign error        = error_reg;
    assign last         = last_out_reg;

    // a new result appears only out of the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside final state");

    // an error result carries zero group fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error) |-> (group_first == '0 && group_last == '0))
        else $error("error result with nonzero group");

    // a good result never has its first row past its last row
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !error) |-> (group_first <= group_last))
        else $error("group first past group last");

    // forward scan never runs beyond its last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_CHK) |-> (scan_word_reg <= scan_end_word_reg))
        else $error("forward scan past window");

    // an accepted query starts evaluation in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (mode == ITEM_QUERY)) |=> (state_reg == ST_EVAL))
        else $error("query not evaluated");

endmodule

`default_nettype wire

// ----- tb/peer_group_boundary_finder_core_test.sv -----
// ----------------------------------------------------------------------------
// peer_group_boundary_finder_core_test
// Self-checking bench for the peer group boundary finder. A queue of load and
// query requests feeds a clocked driver; every accepted request updates a
// bit-accurate predictor of bitmap, group cache and (on writes) registers.
// A clocked monitor checks each result, field by field, against the oldest
// predicted group. Directed corner cases come first, then random phases with
// random register settings, random idling on both sides and one long hold.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_group_boundary_finder_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pgbf_pkg::*;

    // boundary modes not named in the package
    localparam logic [MODE_W-1:0] BMODE_BITMAP     = 2'd2;
    localparam logic [MODE_W-1:0] BMODE_BITMAP_ALT = 2'd3;

    localparam int MAX_IDLE      = 19;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_ITEMS  = 600;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 20;

    typedef struct {
        logic                 kind;
        logic [ADDR_W-1:0]    word_sel;
        logic [WORD_BITS-1:0] word_bits;
        logic [ROW_W-1:0]     row;
        logic                 batch_end;
    } request_t;

    typedef struct {
        logic [ROW_W-1:0] first_row;
        logic [ROW_W-1:0] last_of_group;
        logic             err;
        logic             batch_end;
    } group_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CIDX_W-1:0]    cfg_index = CFG_BOUNDARY_MODE;
    logic [CNT_W-1:0]     cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic                 mode = ITEM_LOAD;
    logic [ADDR_W-1:0]    word_index = '0;
    logic [WORD_BITS-1:0] word_data = '0;
    logic [ROW_W-1:0]     row_index = '0;
    logic                 last_row = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [ROW_W-1:0]     group_first;
    logic [ROW_W-1:0]     group_last;
    logic                 error;
    logic                 last;

    // predictor state
    logic [WORD_BITS-1:0] peer_starts [BITMAP_DEPTH];
    logic [CNT_W-1:0]     cache_first = '0;
    logic [CNT_W-1:0]     cache_end = '0;
    logic [MODE_W-1:0]    bmode = BMODE_PARTITION;
    logic [CNT_W-1:0]     part_rows = '0;
    logic [WCNT_W-1:0]    map_words = '0;

    request_t pending_requests [$];
    group_t   expected_groups [$];
    request_t on_bus;

    int requests_queued = 0;
    int requests_taken = 0;
    int send_wait = 0;
    int stall_left = 0;
    int sender_idle_max = 0;
    int sink_idle_max = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int fail_count = 0;
    int results_seen = 0;
    int cycle_count = 0;

    peer_group_boundary_finder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .word_index   (word_index),
        .word_data    (word_data),
        .row_index    (row_index),
        .last_row     (last_row),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .group_first  (group_first),
        .group_last   (group_last),
        .error        (error),
        .last         (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // group prediction
    // ------------------------------------------------------------------

    function automatic int mapped_bits();
        int w;
        w = (map_words > BITMAP_DEPTH) ? BITMAP_DEPTH : map_words;
        return w * WORD_BITS;
    endfunction

    // last marked row in 1..row inside the map, else 0
    function automatic int find_group_start(int row);
        int lim;
        int p;
        if (row == 0 || map_words == 0)
            return 0;
        lim = row + 1;
        if (lim > mapped_bits())
            lim = mapped_bits();
        for (p = lim - 1; p >= 1; p--)
        begin
            if (peer_starts[p / WORD_BITS][p % WORD_BITS])
                return p;
        end
        return 0;
    endfunction

    // first marked row after the start, inside the partition and the map
    function automatic int find_group_end(int start, int n);
        int lim;
        int p;
        if (map_words == 0 || start + 1 >= n)
            return n;
        lim = (n < mapped_bits()) ? n : mapped_bits();
        for (p = start + 1; p < lim; p++)
        begin
            if (peer_starts[p / WORD_BITS][p % WORD_BITS])
                return p;
        end
        return n;
    endfunction

    function automatic group_t find_peer_group(logic [ROW_W-1:0] row_in, logic flag);
        group_t g;
        int     row;
        int     n;
        int     first;
        int     stop;
        row = row_in;
        n = (part_rows > MAX_ROWS) ? MAX_ROWS : part_rows;
        g.first_row = '0;
        g.last_of_group = '0;
        g.err = 1'b0;
        g.batch_end = flag;
        // out of range: error only, cache untouched
        if (row >= n)
        begin
            g.err = 1'b1;
            return g;
        end
        if (bmode == BMODE_PARTITION)
        begin
            first = 0;
            stop = n;
        end
        else if (bmode == BMODE_SINGLE)
        begin
            first = row;
            stop = row + 1;
        end
        else
        begin
            // bitmap groups, cache reused for a nonzero row inside it
            first = cache_first;
            stop = cache_end;
            if (row == 0 || row < first || row >= stop)
            begin
                first = find_group_start(row);
                stop = find_group_end(first, n);
            end
        end
        cache_first = CNT_W'(first);
        cache_end = CNT_W'(stop);
        g.first_row = ROW_W'(first);
        g.last_of_group = ROW_W'(stop - 1);
        return g;
    endfunction

    function automatic void take_request(request_t req);
        group_t g;
        if (req.kind == ITEM_LOAD)
        begin
            peer_starts[req.word_sel] = req.word_bits;
        end
        else
        begin
            g = find_peer_group(req.row, req.batch_end);
            expected_groups = {expected_groups, g};
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (peer_starts[w])
                peer_starts[w] = '0;
            cache_first = '0;
            cache_end = '0;
        end
        else
        begin
            // request accepted: advance the prediction
            if (item_valid && !item_stall)
            begin
                take_request(on_bus);
                requests_taken++;
                send_wait = $urandom_range(0, sender_idle_max);
            end
            // offer the next request unless the current one is held
            if (!(item_valid && item_stall))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    item_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    on_bus = pending_requests.pop_front();
                    item_valid <= 1'b1;
                    mode <= on_bus.kind;
                    word_index <= on_bus.word_sel;
                    word_data <= on_bus.word_bits;
                    row_index <= on_bus.row;
                    last_row <= on_bus.batch_end;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result stall: short random waits, or a long hold on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            else if (result_valid && !result_stall)
            begin
                stall_left = $urandom_range(0, sink_idle_max);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            result_stall <= (stall_left > 0);
        end
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        group_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_groups.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result first %0d last %0d error %0b",
                                          group_first, group_last, error));
            end
            else
            begin
                want = expected_groups.pop_front();
                if (group_first !== want.first_row)
                    report_mismatch($sformatf("group_first %0d, expected %0d",
                                              group_first, want.first_row));
                if (group_last !== want.last_of_group)
                    report_mismatch($sformatf("group_last %0d, expected %0d",
                                              group_last, want.last_of_group));
                if (error !== want.err)
                    report_mismatch($sformatf("error %0b, expected %0b", error, want.err));
                if (last !== want.batch_end)
                    report_mismatch($sformatf("last %0b, expected %0b", last, want.batch_end));
            end
            results_seen++;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("peer_group_boundary_finder_core_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_load(logic [ADDR_W-1:0] sel, logic [WORD_BITS-1:0] bits);
        request_t req;
        req.kind = ITEM_LOAD;
        req.word_sel = sel;
        req.word_bits = bits;
        req.row = ROW_W'($urandom);
        req.batch_end = 1'($urandom);
        pending_requests = {pending_requests, req};
        requests_queued++;
    endfunction

    function automatic void queue_query(logic [ROW_W-1:0] row, logic flag);
        request_t req;
        req.kind = ITEM_QUERY;
        req.word_sel = ADDR_W'($urandom);
        req.word_bits = {$urandom, $urandom};
        req.row = row;
        req.batch_end = flag;
        pending_requests = {pending_requests, req};
        requests_queued++;
    endfunction

    // bitmap word: 0..4 denser to sparser, 5 empty, 6 full
    function automatic logic [WORD_BITS-1:0] rand_word(int density);
        logic [WORD_BITS-1:0] w;
        int                   k;
        if (density == 5)
            return '0;
        if (density == 6)
            return '1;
        w = {$urandom, $urandom};
        for (k = 0; k < density; k++)
            w &= {$urandom, $urandom};
        return w;
    endfunction

    // wait until every request is taken and every group has come back
    task automatic wait_drained();
        while (requests_taken != requests_queued || expected_groups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three registers, valid held high across the writes
    task automatic write_config(input logic [CNT_W-1:0] mode_val,
                                input logic [CNT_W-1:0] rows_val,
                                input logic [CNT_W-1:0] words_val);
        logic [CIDX_W-1:0] reg_sel [3];
        logic [CNT_W-1:0]  reg_val [3];
        int                i;
        reg_sel = '{CFG_BOUNDARY_MODE, CFG_NUM_ROWS, CFG_BITMAP_WORDS};
        reg_val = '{mode_val, rows_val, words_val};
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_sel[i];
            cfg_data <= reg_val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (reg_sel[i])
                CFG_BOUNDARY_MODE: bmode = reg_val[i][MODE_W-1:0];
                CFG_NUM_ROWS:      part_rows = reg_val[i];
                CFG_BITMAP_WORDS:  map_words = reg_val[i][WCNT_W-1:0];
                default:           ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // one random phase: random registers, a fresh bitmap, then query batches and noise
    task automatic run_random_phase(input bit long_hold, output int made);
        logic [MODE_W-1:0] pick_mode;
        logic              done;
        int                pick;
        int                rows_raw;
        int                n_eff;
        int                used;
        int                words;
        int                density;
        int                budget;
        int                queries;
        int                start;
        int                row;
        int                nxt;
        int                len;
        int                j;
        made = 0;
        queries = 0;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            pick_mode = BMODE_PARTITION;
        else if (pick < 20)
            pick_mode = BMODE_SINGLE;
        else if (pick < 85)
            pick_mode = BMODE_BITMAP;
        else
            pick_mode = BMODE_BITMAP_ALT;
        // mostly small partitions, a few empty, full or oversized
        pick = $urandom_range(0, 99);
        if (pick < 8)
            rows_raw = 0;
        else if (pick < 14)
            rows_raw = MAX_ROWS;
        else if (pick < 20)
            rows_raw = $urandom_range(MAX_ROWS + 1, 8191);
        else if (pick < 30)
            rows_raw = $urandom_range(1, MAX_ROWS);
        else
            rows_raw = $urandom_range(1, 200);
        n_eff = (rows_raw > MAX_ROWS) ? MAX_ROWS : rows_raw;
        used = (n_eff + WORD_BITS - 1) / WORD_BITS;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            words = used;
        else if (pick < 65)
            words = 0;
        else if (pick < 75)
            words = 127;
        else if (pick < 82)
            words = BITMAP_DEPTH;
        else
            words = $urandom_range(0, 127);
        write_config({(CNT_W-MODE_W)'($urandom), pick_mode}, CNT_W'(rows_raw),
                     {(CNT_W-WCNT_W)'($urandom), WCNT_W'(words)});

        sender_idle_max = (long_hold || $urandom_range(0, 1) == 0) ? 0 : MAX_IDLE;
        sink_idle_max = ($urandom_range(0, 1) == 0) ? 0 : MAX_IDLE;
        budget = long_hold ? 90 : $urandom_range(40, 90);
        density = $urandom_range(0, 6);
        if (long_hold)
            hold_requests++;

        // bitmap covering the partition
        for (j = 0; j < used; j++)
        begin
            queue_load(ADDR_W'(j), rand_word(density));
            made++;
        end

        while (made < budget || queries < 20)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70 && n_eff > 0)
            begin
                // ascending batch of rows, last flag on the final one
                start = $urandom_range(0, n_eff - 1);
                len = $urandom_range(1, 16);
                row = start;
                for (j = 0; j < len; j++)
                begin
                    nxt = row + (($urandom_range(0, 3) == 0) ? 2 : 1);
                    done = (j == len - 1) || (nxt >= n_eff);
                    queue_query(ROW_W'(row), done);
                    made++;
                    queries++;
                    if (done)
                        break;
                    row = nxt;
                end
            end
            else if (pick < 85)
            begin
                queue_query(ROW_W'($urandom), 1'($urandom));
                made++;
                queries++;
            end
            else if (pick < 95)
            begin
                queue_load(ADDR_W'($urandom), rand_word(density));
                made++;
            end
            else
            begin
                // rows right at the partition edge
                queue_query(ROW_W'(n_eff - $urandom_range(0, 1)), 1'b1);
                made++;
                queries++;
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int random_made;
        int phase_made;
        int phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // registers at reset: no rows, every query is out of range
        queue_query(ROW_W'(0), 1'b0);
        queue_query(ROW_W'(MAX_ROWS - 1), 1'b1);
        wait_drained();

        // whole partition at the largest size
        write_config(CNT_W'(BMODE_PARTITION), CNT_W'(MAX_ROWS), CNT_W'(0));
        queue_query(ROW_W'(0), 1'b0);
        queue_query(ROW_W'(MAX_ROWS - 1), 1'b1);
        wait_drained();

        // all-ones register data: mode three, oversized row and word counts
        write_config('1, '1, '1);
        queue_load(ADDR_W'(0), 64'h8000_0000_0000_0021);
        queue_load(ADDR_W'(BITMAP_DEPTH - 1), 64'h8000_0000_0000_0000);
        queue_query(ROW_W'(0), 1'b0);
        queue_query(ROW_W'(3), 1'b0);
        queue_query(ROW_W'(5), 1'b0);
        queue_query(ROW_W'(63), 1'b0);
        queue_query(ROW_W'(MAX_ROWS - 1), 1'b0);
        queue_query(ROW_W'(4000), 1'b1);
        wait_drained();

        // each row alone in a one-row partition
        write_config(CNT_W'(BMODE_SINGLE), CNT_W'(1), CNT_W'(1));
        queue_query(ROW_W'(0), 1'b0);
        queue_query(ROW_W'(1), 1'b0);
        queue_query(ROW_W'(MAX_ROWS - 1), 1'b1);
        wait_drained();

        // bitmap mode with no valid words, loads of extreme contents
        write_config(CNT_W'(BMODE_BITMAP), CNT_W'(100), CNT_W'(0));
        queue_load(ADDR_W'(1), '1);
        queue_load(ADDR_W'(2), '0);
        queue_query(ROW_W'(50), 1'b0);
        queue_query(ROW_W'(0), 1'b1);
        wait_drained();

        // random phases, the third one with a long result hold
        random_made = 0;
        phase = 0;
        while (random_made < RANDOM_ITEMS)
        begin
            run_random_phase(phase == 2, phase_made);
            random_made += phase_made;
            phase++;
        end
        wait_drained();

        if (fail_count == 0)
            $display("peer_group_boundary_finder_core_test OK");
        else
            $display("peer_group_boundary_finder_core_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/pgbf_pkg.sv
hw/rtl/pgbf_bit_scan.sv
hw/rtl/peer_group_boundary_finder_core.sv
tb/peer_group_boundary_finder_core_test.sv
